@@ hw/rtl/alu16_pkg.sv @@
// ----------------------------------------------------------------------------
// alu16_pkg
// Types, opcodes and constants shared by the 16-bit CPU execute ALU.
// ----------------------------------------------------------------------------
package alu16_pkg;

	typedef enum logic [4:0] {
		OP_NOP = 5'h00,
		OP_SET = 5'h01,
		OP_ADD = 5'h02,
		OP_SUB = 5'h03,
		OP_MUL = 5'h04,
		OP_MLI = 5'h05,
		OP_DIV = 5'h06,
		OP_DVI = 5'h07,
		OP_MOD = 5'h08,
		OP_MDI = 5'h09,
		OP_AND = 5'h0A,
		OP_BOR = 5'h0B,
		OP_XOR = 5'h0C,
		OP_SHR = 5'h0D,
		OP_ASR = 5'h0E,
		OP_SHL = 5'h0F,
		OP_IFB = 5'h10,
		OP_IFC = 5'h11,
		OP_IFE = 5'h12,
		OP_IFN = 5'h13,
		OP_IFG = 5'h14,
		OP_IFA = 5'h15,
		OP_IFL = 5'h16,
		OP_IFU = 5'h17,
		OP_ADX = 5'h1A,
		OP_SBX = 5'h1B,
		OP_STI = 5'h1E,
		OP_STD = 5'h1F
	} op_t;

	localparam logic [1:0] STEP_NONE = 2'd0;
	localparam logic [1:0] STEP_INC  = 2'd1;
	localparam logic [1:0] STEP_DEC  = 2'd2;

	localparam logic [5:0]  SHIFT_CAP = 6'd32;
	localparam logic [31:0] SPAN16    = 32'h0001_0000;

	// divider: 32 quotient bits, 4 per stage
	localparam int DIV_STAGES = 8;
	localparam int DIV_STEPS  = 4;
	localparam int MOD_STAGE  = 4;

	typedef struct packed {
		logic [4:0]  command;
		logic [15:0] b_value;
		logic [15:0] a_value;
		logic [15:0] ex_in;
	} alu_req_t;

	typedef struct packed {
		logic [15:0] result;
		logic        write_back;
		logic [15:0] ex_out;
		logic        ex_written;
		logic        is_test;
		logic        test_true;
		logic [1:0]  index_step;
	} alu_rsp_t;

	typedef struct packed {
		logic [4:0]  op;
		logic [15:0] b;
		logic [15:0] a;
		logic [15:0] ex;
		logic [15:0] am;
		logic [15:0] dvd;
		logic        negq;
		logic        negr;
		logic [15:0] rem;
		logic [31:0] q;
		logic [15:0] rmod;
		logic [31:0] prod;
		logic [15:0] res;
		logic [15:0] exo;
		logic        wb;
		logic        exw;
		logic        tst;
		logic        tt;
		logic [1:0]  step;
	} pipe_t;

endpackage

@@ hw/rtl/sixteen_bit_cpu_alu_with_excess.sv @@
// ----------------------------------------------------------------------------
// sixteen_bit_cpu_alu_with_excess
// Execute ALU for the basic two-operand opcodes of a 16-bit CPU.
// ----------------------------------------------------------------------------
// Request channel (req_valid / req_stall / req) carries opcode, b, a and the
// current EX. Response channel (rsp_valid / rsp_stall / rsp) carries result,
// write-back flag, new EX and its flag, IF outcome and the I/J step code.
// The pipeline has one input register, eight divider stages of four
// restoring steps each, and the output register. The 32-step divider sets
// the depth; every opcode rides the same pipeline so order is kept.
// Throughput is one request per cycle while the response is not stalled.
// A stalled response freezes the whole pipeline; req_stall is high exactly
// while a valid response is held by rsp_stall. Nothing is lost or repeated.
// Reset clears all valid bits; the pipeline is empty afterwards.
// ----------------------------------------------------------------------------
module sixteen_bit_cpu_alu_with_excess (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  alu16_pkg::alu_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output alu16_pkg::alu_rsp_t rsp
);
	import alu16_pkg::*;

	logic     en;
	pipe_t    p_s [0:DIV_STAGES];
	logic     v_s [0:DIV_STAGES];
	pipe_t    nx  [1:DIV_STAGES];
	pipe_t    in_nx;
	alu_rsp_t rsp_nx;
	alu_rsp_t rsp_q;
	logic     rsp_v_q;

	assign en        = !(rsp_v_q && rsp_stall);
	assign req_stall = !en;
	assign rsp_valid = rsp_v_q;
	assign rsp       = rsp_q;

	// input stage: operand magnitudes for the signed divide
	always_comb begin
		logic sgn;
		sgn = (req.command == OP_DVI) || (req.command == OP_MDI);
		in_nx      = '0;
		in_nx.op   = req.command;
		in_nx.b    = req.b_value;
		in_nx.a    = req.a_value;
		in_nx.ex   = req.ex_in;
		in_nx.dvd  = (sgn && req.b_value[15]) ? 16'(-req.b_value) : req.b_value;
		in_nx.am   = (sgn && req.a_value[15]) ? 16'(-req.a_value) : req.a_value;
		in_nx.negq = sgn && (req.b_value[15] ^ req.a_value[15]);
		in_nx.negr = sgn && req.b_value[15];
	end

	always_comb begin
		logic [16:0] rem17;
		logic [31:0] t32;
		logic [47:0] t48;
		logic [17:0] t18;
		logic [5:0]  sh;
		logic signed [33:0] pr;
		pipe_t c;
		rem17 = '0;
		t32 = '0; t48 = '0; t18 = '0;
		sh = '0;
		pr = '0;
		for (int k = 1; k <= DIV_STAGES; k++) begin
			c = p_s[k-1];
			for (int j = 0; j < DIV_STEPS; j++) begin
				rem17 = {c.rem, c.dvd[15]};
				c.dvd = {c.dvd[14:0], 1'b0};
				if (rem17 >= {1'b0, c.am}) begin
					rem17 = rem17 - {1'b0, c.am};
					c.q   = {c.q[30:0], 1'b1};
				end else begin
					c.q   = {c.q[30:0], 1'b0};
				end
				c.rem = rem17[15:0];
			end
			if (k == MOD_STAGE) begin
				c.rmod = c.rem;
			end
			if (k == 1) begin
				sh  = (c.a > 16'(SHIFT_CAP)) ? SHIFT_CAP : c.a[5:0];
				pr  = $signed({(c.op == OP_MLI) && c.b[15], c.b}) *
				      $signed({(c.op == OP_MLI) && c.a[15], c.a});
				c.prod = pr[31:0];
				c.res = '0; c.exo = c.ex; c.wb = 1'b0; c.exw = 1'b0;
				c.tst = 1'b0; c.tt = 1'b0; c.step = STEP_NONE;
				t32 = '0; t48 = '0; t18 = '0;
				case (c.op)
					OP_SET: begin c.res = c.a; c.wb = 1'b1; end
					OP_ADD: begin
						t32 = {16'd0, c.b} + {16'd0, c.a};
						c.res = t32[15:0]; c.exo = t32[31:16]; c.wb = 1'b1; c.exw = 1'b1;
					end
					OP_SUB: begin
						t32 = {16'd0, c.b} - {16'd0, c.a};
						c.res = t32[15:0]; c.exo = t32[31:16]; c.wb = 1'b1; c.exw = 1'b1;
					end
					OP_MUL, OP_MLI, OP_DIV, OP_DVI: begin c.wb = 1'b1; c.exw = 1'b1; end
					OP_MOD, OP_MDI: c.wb = 1'b1;
					OP_AND: begin c.res = c.b & c.a; c.wb = 1'b1; end
					OP_BOR: begin c.res = c.b | c.a; c.wb = 1'b1; end
					OP_XOR: begin c.res = c.b ^ c.a; c.wb = 1'b1; end
					OP_SHR: begin
						t32 = {c.b, 16'd0} >> sh;
						c.res = t32[31:16]; c.exo = t32[15:0]; c.wb = 1'b1; c.exw = 1'b1;
					end
					OP_ASR: begin
						t32 = 32'($signed({c.b, 16'd0}) >>> sh);
						c.res = t32[31:16]; c.exo = t32[15:0]; c.wb = 1'b1; c.exw = 1'b1;
					end
					OP_SHL: begin
						t48 = {32'd0, c.b} << sh;
						c.res = t48[15:0]; c.exo = t48[31:16]; c.wb = 1'b1; c.exw = 1'b1;
					end
					OP_IFB: begin c.tst = 1'b1; c.tt = (c.b & c.a) != 16'd0; end
					OP_IFC: begin c.tst = 1'b1; c.tt = (c.b & c.a) == 16'd0; end
					OP_IFE: begin c.tst = 1'b1; c.tt = c.b == c.a; end
					OP_IFN: begin c.tst = 1'b1; c.tt = c.b != c.a; end
					OP_IFG: begin c.tst = 1'b1; c.tt = c.b > c.a; end
					OP_IFA: begin c.tst = 1'b1; c.tt = $signed(c.b) > $signed(c.a); end
					OP_IFL: begin c.tst = 1'b1; c.tt = c.b < c.a; end
					OP_IFU: begin c.tst = 1'b1; c.tt = $signed(c.b) < $signed(c.a); end
					OP_ADX: begin
						t18 = {2'd0, c.b} + {2'd0, c.a} + {2'd0, c.ex};
						c.res = t18[15:0]; c.exo = {14'd0, t18[17:16]};
						c.wb = 1'b1; c.exw = 1'b1;
					end
					OP_SBX: begin
						t32 = {16'd0, c.b} - {16'd0, c.a} -
						      ((c.ex != 16'd0) ? (SPAN16 - {16'd0, c.ex}) : 32'd0);
						c.res = t32[15:0]; c.exo = t32[31:16]; c.wb = 1'b1; c.exw = 1'b1;
					end
					OP_STI: begin c.res = c.a; c.wb = 1'b1; c.step = STEP_INC; end
					OP_STD: begin c.res = c.a; c.wb = 1'b1; c.step = STEP_DEC; end
					default: ;
				endcase
			end
			nx[k] = c;
		end
	end

	// final select: product and divider results
	always_comb begin
		pipe_t f;
		logic [31:0] qs;
		logic [15:0] qh;
		logic        dz;
		f  = p_s[DIV_STAGES];
		dz = (f.am == 16'd0);
		qs = f.negq ? 32'(-f.q) : f.q;
		qh = f.negq ? 16'(-f.q[31:16]) : f.q[31:16];
		rsp_nx.result     = f.res;
		rsp_nx.ex_out     = f.exo;
		rsp_nx.write_back = f.wb;
		rsp_nx.ex_written = f.exw;
		rsp_nx.is_test    = f.tst;
		rsp_nx.test_true  = f.tt;
		rsp_nx.index_step = f.step;
		case (f.op)
			OP_MUL, OP_MLI: begin
				rsp_nx.result = f.prod[15:0];
				rsp_nx.ex_out = f.prod[31:16];
			end
			OP_DIV, OP_DVI: begin
				rsp_nx.result = dz ? 16'd0 : qh;
				rsp_nx.ex_out = dz ? 16'd0 : qs[15:0];
			end
			OP_MOD, OP_MDI: begin
				rsp_nx.result = dz ? 16'd0 : (f.negr ? 16'(-f.rmod) : f.rmod);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_STAGES; k++) v_s[k] <= 1'b0;
			rsp_v_q <= 1'b0;
		end else if (en) begin
			v_s[0] <= req_valid;
			for (int k = 1; k <= DIV_STAGES; k++) v_s[k] <= v_s[k-1];
			rsp_v_q <= v_s[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s[0] <= in_nx;
			for (int k = 1; k <= DIV_STAGES; k++) p_s[k] <= nx[k];
			rsp_q <= rsp_nx;
		end
	end

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (rsp_valid && rsp_stall))
		else $error("request stalled without a held response");

	a_no_wb_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.write_back) |-> (rsp.result == 16'd0))
		else $error("result nonzero without write-back");

	a_test_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.is_test) |-> !rsp.test_true)
		else $error("test_true outside an IF opcode");

	a_ex_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.is_test) |-> (!rsp.write_back && !rsp.ex_written))
		else $error("IF opcode writes a register");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the 16-bit CPU execute ALU against an in-bench model of each opcode.
// Directed edge cases first, then random requests with random gaps and stalls
// on both channels; responses are matched in order, field by field.
// ----------------------------------------------------------------------------
module tb;
	import alu16_pkg::*;

	class alu_scoreboard;
		alu_rsp_t pending[$];
		int errors;
		int checked;

		function new();
			errors = 0;
			checked = 0;
		endfunction

		function void note_request(alu_rsp_t exp);
			pending.push_back(exp);
		endfunction

		task check_response(alu_rsp_t got);
			alu_rsp_t exp;
			if (pending.size() == 0) begin
				report_mismatch("response with nothing pending", 64'd0, 64'(got));
				return;
			end
			exp = pending[0];
			pending.delete(0);
			checked++;
			if (got.result !== exp.result)
				report_mismatch("result", 64'(exp.result), 64'(got.result));
			if (got.write_back !== exp.write_back)
				report_mismatch("write_back", 64'(exp.write_back), 64'(got.write_back));
			if (got.ex_out !== exp.ex_out)
				report_mismatch("ex_out", 64'(exp.ex_out), 64'(got.ex_out));
			if (got.ex_written !== exp.ex_written)
				report_mismatch("ex_written", 64'(exp.ex_written), 64'(got.ex_written));
			if (got.is_test !== exp.is_test)
				report_mismatch("is_test", 64'(exp.is_test), 64'(got.is_test));
			if (got.test_true !== exp.test_true)
				report_mismatch("test_true", 64'(exp.test_true), 64'(got.test_true));
			if (got.index_step !== exp.index_step)
				report_mismatch("index_step", 64'(exp.index_step), 64'(got.index_step));
		endtask

		task report_mismatch(string what, logic [63:0] exp, logic [63:0] got);
			errors++;
			if (errors <= 40)
				$display("mismatch %0t: %s expected %h got %h", $time, what, exp, got);
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	alu_req_t req;
	logic rsp_valid;
	logic rsp_stall;
	alu_rsp_t rsp;
	alu_scoreboard sb;
	int sent;
	bit stim_done;

	sixteen_bit_cpu_alu_with_excess dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	function automatic alu_rsp_t alu_predict(alu_req_t r);
		alu_rsp_t o;
		logic [15:0] b, a, ex;
		logic signed [31:0] sb32, sa32;
		logic [31:0] t;
		logic [63:0] w;
		logic [5:0] sh;
		b = r.b_value;
		a = r.a_value;
		ex = r.ex_in;
		sb32 = $signed(b);
		sa32 = $signed(a);
		sh = (a > 16'd32) ? 6'd32 : a[5:0];
		o = '0;
		o.ex_out = ex;
		case (op_t'(r.command))
			OP_SET: begin o.result = a; o.write_back = 1'b1; end
			OP_ADD, OP_SUB, OP_MUL, OP_MLI, OP_ADX, OP_SBX: begin
				case (op_t'(r.command))
					OP_ADD: t = {16'd0, b} + {16'd0, a};
					OP_SUB: t = {16'd0, b} - {16'd0, a};
					OP_MUL: t = {16'd0, b} * {16'd0, a};
					OP_MLI: t = sb32 * sa32;
					OP_ADX: t = {16'd0, b} + {16'd0, a} + {16'd0, ex};
					default: begin
						t = {16'd0, b} - {16'd0, a};
						if (ex != 16'd0) t = t - (32'h10000 - {16'd0, ex});
					end
				endcase
				o.result = t[15:0];
				o.ex_out = t[31:16];
				o.write_back = 1'b1;
				o.ex_written = 1'b1;
			end
			OP_DIV: begin
				o.write_back = 1'b1; o.ex_written = 1'b1;
				if (a == 16'd0) begin o.result = 16'd0; o.ex_out = 16'd0; end
				else begin
					o.result = b / a;
					t = {b, 16'd0} / {16'd0, a};
					o.ex_out = t[15:0];
				end
			end
			OP_DVI: begin
				o.write_back = 1'b1; o.ex_written = 1'b1;
				if (a == 16'd0) begin o.result = 16'd0; o.ex_out = 16'd0; end
				else begin
					t = sb32 / sa32;
					o.result = t[15:0];
					w = (64'(signed'(sb32)) * 64'sd65536) / 64'(signed'(sa32));
					o.ex_out = w[15:0];
				end
			end
			OP_MOD: begin o.write_back = 1'b1; o.result = (a == 16'd0) ? 16'd0 : b % a; end
			OP_MDI: begin
				o.write_back = 1'b1;
				t = (a == 16'd0) ? 32'sd0 : sb32 % sa32;
				o.result = t[15:0];
			end
			OP_AND: begin o.write_back = 1'b1; o.result = b & a; end
			OP_BOR: begin o.write_back = 1'b1; o.result = b | a; end
			OP_XOR: begin o.write_back = 1'b1; o.result = b ^ a; end
			OP_SHR: begin
				w = {16'd0, b, 16'd0} >> sh;
				o.result = w[31:16]; o.ex_out = w[15:0];
				o.write_back = 1'b1; o.ex_written = 1'b1;
			end
			OP_ASR: begin
				w = $signed({{32{b[15]}}, b, 16'd0}) >>> sh;
				o.result = w[31:16]; o.ex_out = w[15:0];
				o.write_back = 1'b1; o.ex_written = 1'b1;
			end
			OP_SHL: begin
				w = {32'd0, b} << sh;
				o.result = w[15:0]; o.ex_out = w[31:16];
				o.write_back = 1'b1; o.ex_written = 1'b1;
			end
			OP_IFB: begin o.is_test = 1'b1; o.test_true = (b & a) != 16'd0; end
			OP_IFC: begin o.is_test = 1'b1; o.test_true = (b & a) == 16'd0; end
			OP_IFE: begin o.is_test = 1'b1; o.test_true = b == a; end
			OP_IFN: begin o.is_test = 1'b1; o.test_true = b != a; end
			OP_IFG: begin o.is_test = 1'b1; o.test_true = b > a; end
			OP_IFA: begin o.is_test = 1'b1; o.test_true = sb32 > sa32; end
			OP_IFL: begin o.is_test = 1'b1; o.test_true = b < a; end
			OP_IFU: begin o.is_test = 1'b1; o.test_true = sb32 < sa32; end
			OP_STI: begin o.result = a; o.write_back = 1'b1; o.index_step = STEP_INC; end
			OP_STD: begin o.result = a; o.write_back = 1'b1; o.index_step = STEP_DEC; end
			default: ;
		endcase
		return o;
	endfunction

	function automatic logic [15:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'h7FFF;
			4: return 16'($urandom_range(0, 40));
			5: return 16'hFFFF - 16'($urandom_range(0, 40));
			default: return 16'($urandom);
		endcase
	endfunction

	task send_request(logic [4:0] cmd, logic [15:0] b, logic [15:0] a, logic [15:0] ex);
		int gap;
		alu_req_t r;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		r.command = cmd;
		r.b_value = b;
		r.a_value = a;
		r.ex_in = ex;
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		sb.note_request(alu_predict(r));
		sent++;
	endtask

	initial begin
		sb = new();
		sent = 0;
		stim_done = 0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_request(OP_NOP, 16'h1234, 16'h5678, 16'hABCD);
		send_request(5'h18, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_request(5'h1C, 16'h0001, 16'h0002, 16'h0003);
		send_request(OP_DIV, 16'h1234, 16'h0000, 16'h5555);
		send_request(OP_DVI, 16'h8000, 16'h0000, 16'h5555);
		send_request(OP_MOD, 16'hFFFF, 16'h0000, 16'h1111);
		send_request(OP_MDI, 16'h8001, 16'h0000, 16'h1111);
		send_request(OP_DVI, 16'h8000, 16'hFFFF, 16'h2222);
		send_request(OP_MDI, 16'h8000, 16'hFFFF, 16'h0000);
		send_request(OP_SHR, 16'hFFFF, 16'h0021, 16'h0000);
		send_request(OP_ASR, 16'h8000, 16'hFFFF, 16'h0000);
		send_request(OP_SHL, 16'hFFFF, 16'h0020, 16'h0000);
		send_request(OP_SHL, 16'hFFFF, 16'h001F, 16'h0000);
		send_request(OP_SUB, 16'h0000, 16'hFFFF, 16'h0000);
		send_request(OP_ADX, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_request(OP_SBX, 16'h0000, 16'hFFFF, 16'h0000);
		send_request(OP_SBX, 16'h0000, 16'hFFFF, 16'h0001);
		send_request(OP_MLI, 16'h8000, 16'h8000, 16'h0000);
		for (int op = 0; op < 32; op++)
			send_request(op[4:0], pick_operand(), pick_operand(), pick_operand());
		while (sent < 1650) begin
			send_request(5'($urandom), pick_operand(), pick_operand(), pick_operand());
		end
		req_valid <= 1'b0;
		stim_done = 1;
	end

	initial begin
		int hold;
		rsp_stall = 1'b0;
		forever begin
			hold = $urandom_range(0, 4);
			if (hold != 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
			sb.check_response(rsp);
		end
	end

	initial begin
		wait (stim_done);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("sent %0d requests over all 32 opcode codes, checked %0d responses",
			sent, sb.checked);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#200000;
		$display("timeout");
		$display("status: fail");
		$finish;
	end
endmodule

@@ files.f @@
hw/rtl/alu16_pkg.sv
hw/rtl/sixteen_bit_cpu_alu_with_excess.sv
test/tb.sv
